### rtl/cdst_pkg.sv
// Shared types, codes and calendar helper functions for the calendar date stepper.
package cdst_pkg;

    // Operation codes carried in the cmd field
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_NEXT = 2'd1;
    localparam logic [1:0] OP_PREV = 2'd2;
    localparam logic [1:0] OP_ADD  = 2'd3;

    // Fixed field widths of the channel beats
    localparam int FIELD_YEAR_W   = 16;
    localparam int FIELD_OFFSET_W = 16;

    // Year-mod-400 residue width and bound
    localparam int MOD_W = 9;
    localparam logic [MOD_W-1:0] MOD_LAST = 9'd399;

    // Reciprocal of 400 for years below 2^24: quotient = (year * MOD_RECIP) >> MOD_RECIP_SHIFT
    localparam int MOD_RECIP_W     = 25;
    localparam int MOD_RECIP_SHIFT = 33;
    localparam logic [MOD_RECIP_W-1:0] MOD_RECIP = 25'd21474837;

    typedef struct packed {
        logic [1:0]                       cmd;
        logic [4:0]                       new_day;
        logic [3:0]                       new_month;
        logic [FIELD_YEAR_W-1:0]          new_year;
        logic signed [FIELD_OFFSET_W-1:0] day_offset;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]              out_day;
        logic [3:0]              out_month;
        logic [FIELD_YEAR_W-1:0] out_year;
        logic                    error;
    } out_beat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // latch the input beat into the working registers
        logic mod_step;   // finish the year-mod-400 reduction
        logic walk_step;  // move one month forward or back
        logic commit;     // write the result and update the held date
        logic err;        // refuse: keep the held date and flag the result
    } cdst_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_range;   // working day lies within the working month
        logic walk_fail;  // the next month step would leave the year range
        logic load_ok;    // working date is a legal date
    } cdst_stat_t;

    // Leap test from the year residue mod 400
    function automatic logic is_leap(input logic [MOD_W-1:0] r);
        logic century;
        century = (r == 9'd0) || (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
        return ((r[1:0] == 2'b00) && !century) || (r == 9'd0);
    endfunction

    // Month length; months outside 1..12 read as 31
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/cdst_ctrl.sv
// Controller state machine for the calendar date stepper.
module cdst_ctrl
    import cdst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] op,
    output logic       m_valid,
    input  logic       m_ready,
    input  cdst_stat_t stat,
    output cdst_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MOD   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_WALK  = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic           m_valid_reg, m_valid_next;
    logic           slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign slot_free = !m_valid_reg || m_ready;

    // Sequence load check and month walk
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (op == OP_LOAD) ? ST_MOD : ST_WALK;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                if (slot_free) begin
                    cmd.commit = 1'b1;
                    cmd.err    = !stat.load_ok;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (stat.in_range || stat.walk_fail) begin
                    if (slot_free) begin
                        cmd.commit = 1'b1;
                        cmd.err    = !stat.in_range;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Raise result valid on commit, drop it when the beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/cdst_datapath.sv
// Datapath for the calendar date stepper: held date, working date and result register.
module cdst_datapath
    import cdst_pkg::*;
#(
    parameter int YEAR_BITS   = 16,
    parameter int OFFSET_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_beat_t   s_data,
    input  cdst_cmd_t  cmd,
    output cdst_stat_t stat,
    output out_beat_t  m_data
);

    localparam int DW = OFFSET_BITS + 2;
    localparam int PW = YEAR_BITS + MOD_RECIP_W;
    localparam int QW = PW - MOD_RECIP_SHIFT;
    localparam logic [YEAR_BITS-1:0]  YEAR_MAX  = '1;
    localparam logic [YEAR_BITS-1:0]  YEAR_ONE  = YEAR_BITS'(1);
    localparam logic signed [DW-1:0]  ONE_D     = DW'(1);
    localparam logic signed [DW-1:0]  MINUS_ONE = '1;

    // Held date
    logic [4:0]           cur_day_reg;
    logic [3:0]           cur_month_reg;
    logic [YEAR_BITS-1:0] cur_year_reg;
    logic [MOD_W-1:0]     cur_mod_reg;

    // Working date
    logic signed [DW-1:0] day_reg;
    logic [3:0]           month_reg;
    logic [YEAR_BITS-1:0] year_reg;
    logic [MOD_W-1:0]     mod_reg;
    logic [QW-1:0]        quo_reg;

    out_beat_t            res_reg;

    logic [YEAR_BITS-1:0]   year_in;
    logic [OFFSET_BITS-1:0] off_raw;
    logic signed [DW-1:0]   delta;
    logic signed [DW-1:0]   cur_day_ext;
    logic [FIELD_YEAR_W-1:0] cur_year_out;
    logic [FIELD_YEAR_W-1:0] work_year_out;

    logic [4:0]           dim_cur, dim_prev;
    logic signed [DW-1:0] dim_cur_ext, dim_prev_ext;
    logic [3:0]           prev_month;
    logic [YEAR_BITS-1:0] prev_year;
    logic [MOD_W-1:0]     prev_mod, inc_mod;
    logic                 go_fwd;
    logic [PW-1:0]        mod_prod;
    logic [YEAR_BITS-1:0] quo_ext;
    logic [YEAR_BITS-1:0] quo_x400;
    logic [YEAR_BITS-1:0] year_rem;

    // Fit the fixed-width fields to the parameter widths
    if (YEAR_BITS <= FIELD_YEAR_W) begin : g_year_narrow
        assign year_in       = s_data.new_year[YEAR_BITS-1:0];
        assign cur_year_out  = FIELD_YEAR_W'(cur_year_reg);
        assign work_year_out = FIELD_YEAR_W'(year_reg);
    end else begin : g_year_wide
        assign year_in       = YEAR_BITS'(s_data.new_year);
        assign cur_year_out  = cur_year_reg[FIELD_YEAR_W-1:0];
        assign work_year_out = year_reg[FIELD_YEAR_W-1:0];
    end

    if (OFFSET_BITS <= FIELD_OFFSET_W) begin : g_off_narrow
        assign off_raw = s_data.day_offset[OFFSET_BITS-1:0];
    end else begin : g_off_wide
        assign off_raw = {{(OFFSET_BITS-FIELD_OFFSET_W){1'b0}}, s_data.day_offset};
    end

    assign cur_day_ext = {{(DW-5){1'b0}}, cur_day_reg};

    // Pick the day delta for the step commands
    always_comb begin
        case (s_data.cmd)
            OP_NEXT: delta = ONE_D;
            OP_PREV: delta = MINUS_ONE;
            default: delta = {{2{off_raw[OFFSET_BITS-1]}}, off_raw};
        endcase
    end

    // Month lengths of the working month and of the month before it
    assign prev_month = (month_reg == 4'd1) ? 4'd12 : month_reg - 4'd1;
    assign prev_year  = (month_reg == 4'd1) ? year_reg - YEAR_ONE : year_reg;
    assign prev_mod   = (month_reg != 4'd1) ? mod_reg
                      : ((mod_reg == '0) ? MOD_LAST : mod_reg - MOD_W'(1));
    assign inc_mod    = (mod_reg == MOD_LAST) ? '0 : mod_reg + MOD_W'(1);

    assign dim_cur      = days_in(month_reg, is_leap(mod_reg));
    assign dim_prev     = days_in(prev_month, is_leap(prev_mod));
    assign dim_cur_ext  = {{(DW-5){1'b0}}, dim_cur};
    assign dim_prev_ext = {{(DW-5){1'b0}}, dim_prev};

    assign go_fwd = (day_reg > dim_cur_ext);

    // Status toward the controller
    always_comb begin
        stat.in_range  = (day_reg >= ONE_D) && (day_reg <= dim_cur_ext);
        stat.walk_fail = go_fwd ? ((month_reg == 4'd12) && (year_reg == YEAR_MAX))
                                : ((month_reg == 4'd1) && (year_reg == YEAR_ONE));
        stat.load_ok   = stat.in_range && (month_reg >= 4'd1) && (month_reg <= 4'd12)
                       && (year_reg != '0);
    end

    // Year mod 400: reciprocal multiply at accept, then subtract 400 times the quotient
    assign mod_prod = {{MOD_RECIP_W{1'b0}}, year_in} * {{YEAR_BITS{1'b0}}, MOD_RECIP};
    assign quo_ext  = {{(YEAR_BITS-QW){1'b0}}, quo_reg};
    assign quo_x400 = (quo_ext << 8) + (quo_ext << 7) + (quo_ext << 4);
    assign year_rem = year_reg - quo_x400;

    // Working date: load, reduce, walk
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (s_data.cmd == OP_LOAD) begin
                day_reg   <= {{(DW-5){1'b0}}, s_data.new_day};
                month_reg <= s_data.new_month;
                year_reg  <= year_in;
                quo_reg   <= mod_prod[PW-1 -: QW];
                mod_reg   <= '0;
            end else begin
                day_reg   <= cur_day_ext + delta;
                month_reg <= cur_month_reg;
                year_reg  <= cur_year_reg;
                mod_reg   <= cur_mod_reg;
            end
        end else if (cmd.mod_step) begin
            mod_reg <= year_rem[MOD_W-1:0];
        end else if (cmd.walk_step) begin
            if (go_fwd) begin
                day_reg <= day_reg - dim_cur_ext;
                if (month_reg == 4'd12) begin
                    month_reg <= 4'd1;
                    year_reg  <= year_reg + YEAR_ONE;
                    mod_reg   <= inc_mod;
                end else begin
                    month_reg <= month_reg + 4'd1;
                end
            end else begin
                day_reg   <= day_reg + dim_prev_ext;
                month_reg <= prev_month;
                year_reg  <= prev_year;
                mod_reg   <= prev_mod;
            end
        end
    end

    // Held date: update only on an accepted commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_day_reg   <= 5'd1;
            cur_month_reg <= 4'd1;
            cur_year_reg  <= YEAR_ONE;
            cur_mod_reg   <= MOD_W'(1);
        end else if (cmd.commit && !cmd.err) begin
            cur_day_reg   <= day_reg[4:0];
            cur_month_reg <= month_reg;
            cur_year_reg  <= year_reg;
            cur_mod_reg   <= mod_reg;
        end
    end

    // Result beat
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_reg.error <= cmd.err;
            if (cmd.err) begin
                res_reg.out_day   <= cur_day_reg;
                res_reg.out_month <= cur_month_reg;
                res_reg.out_year  <= cur_year_out;
            end else begin
                res_reg.out_day   <= day_reg[4:0];
                res_reg.out_month <= month_reg;
                res_reg.out_year  <= work_year_out;
            end
        end
    end

    assign m_data = res_reg;

endmodule

### rtl/calendar_date_stepper_unit.sv
// Top level of the calendar date stepper: controller plus datapath.
//
// Holds one Gregorian date and takes one command per input beat: load a date
// (checked; a bad date is flagged and the date kept), next day, previous day,
// or add a signed day offset. Each beat returns one result beat with the date
// held afterwards and an error flag; a step that would leave years
// 1..2^YEAR_BITS-1 is refused and flagged. A load runs a reciprocal multiply
// at accept and a subtract in the next cycle to give the year residue mod 400
// for the leap rule, then the check; next and previous day go straight to
// the walk state, and an add takes one walk step per month boundary crossed.
// The month walk runs on a single working date register set, one month per
// cycle, and one command is in work at a time. A finished result sits in the
// output register, so the next command is taken while it waits.
module calendar_date_stepper_unit
    import cdst_pkg::*;
#(
    parameter int YEAR_BITS   = 16,
    parameter int OFFSET_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    cdst_cmd_t  cmd;
    cdst_stat_t stat;

    cdst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (s_data.cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cdst_datapath #(
        .YEAR_BITS   (YEAR_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

### tb/sv/date_result_checker.sv
// Checker for the calendar date stepper: predicts each result beat and compares it.
`timescale 1ns / 1ps

module date_result_checker
    import cdst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        mismatches,
    output int        pending
);

    localparam int YEAR_LIMIT = (1 << FIELD_YEAR_W) - 1;

    // Date held by the predictor
    int held_day;
    int held_month;
    int held_year;

    out_beat_t expected_dates[$];

    initial begin
        mismatches = 0;
        pending    = 0;
        held_day   = 1;
        held_month = 1;
        held_year  = 1;
    end

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Month outside 1..12 reads as 31 days
    function automatic int month_days(int m, int y);
        case (m)
            2:       return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // Walk the held date by delta days; keep it and return 0 if the year range is left
    function automatic bit shift_held_date(int delta);
        int d;
        int m;
        int y;
        d = held_day + delta;
        m = held_month;
        y = held_year;
        while (d > month_days(m, y)) begin
            d -= month_days(m, y);
            m++;
            if (m > 12) begin
                m = 1;
                y++;
                if (y > YEAR_LIMIT) return 1'b0;
            end
        end
        while (d < 1) begin
            m--;
            if (m < 1) begin
                m = 12;
                y--;
                if (y < 1) return 1'b0;
            end
            d += month_days(m, y);
        end
        held_day   = d;
        held_month = m;
        held_year  = y;
        return 1'b1;
    endfunction

    // Apply one command beat and return the date it leaves behind
    function automatic out_beat_t step_date(in_beat_t b);
        out_beat_t r;
        bit        refused;
        int        d;
        int        m;
        int        y;
        refused = 1'b0;
        case (b.cmd)
            OP_LOAD: begin
                d = int'(b.new_day);
                m = int'(b.new_month);
                y = int'(b.new_year);
                if (m < 1 || m > 12 || d < 1 || y < 1 || d > month_days(m, y)) begin
                    refused = 1'b1;
                end else begin
                    held_day   = d;
                    held_month = m;
                    held_year  = y;
                end
            end
            OP_NEXT: refused = !shift_held_date(1);
            OP_PREV: refused = !shift_held_date(-1);
            default: refused = !shift_held_date(int'(b.day_offset));
        endcase
        r.out_day   = 5'(held_day);
        r.out_month = 4'(held_month);
        r.out_year  = 16'(held_year);
        r.error     = refused;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Retire result beats first, then predict the command beat of this edge
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            held_day   = 1;
            held_month = 1;
            held_year  = 1;
            expected_dates.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d/%0d/%0d err %0b",
                        m_data.out_day, m_data.out_month, m_data.out_year, m_data.error));
                end else begin
                    want = expected_dates.pop_front();
                    if (m_data.out_day !== want.out_day)
                        report_mismatch($sformatf("day %0d, want %0d",
                            m_data.out_day, want.out_day));
                    if (m_data.out_month !== want.out_month)
                        report_mismatch($sformatf("month %0d, want %0d",
                            m_data.out_month, want.out_month));
                    if (m_data.out_year !== want.out_year)
                        report_mismatch($sformatf("year %0d, want %0d",
                            m_data.out_year, want.out_year));
                    if (m_data.error !== want.error)
                        report_mismatch($sformatf("error %0b, want %0b",
                            m_data.error, want.error));
                end
            end
            if (s_valid && s_ready) begin
                expected_dates.push_back(step_date(s_data));
            end
        end
        pending = expected_dates.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the calendar date stepper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import cdst_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    int mismatches;
    int pending;
    int items_sent = 0;
    int burst_left = 0;

    always #2 aclk = ~aclk;

    calendar_date_stepper_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    date_result_checker u_date_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic in_beat_t make_beat(int op, int d, int m, int y, int off);
        in_beat_t b;
        b.cmd        = 2'(op);
        b.new_day    = 5'(d);
        b.new_month  = 4'(m);
        b.new_year   = 16'(y);
        b.day_offset = 16'(off);
        return b;
    endfunction

    // Offer one beat; start a new burst after a random gap when the old one runs out
    task automatic send_beat(input in_beat_t b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Receiver: random ready runs and stalls, plus one long hold-off to fill the block
    initial begin : result_sink
        int run_left;
        int stall_left;
        int hold_left;
        bit hold_done;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && items_sent >= 150) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else begin
                run_left   = $urandom_range(0, 40);
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int ops;
        int pick;
        int off;
        int y;
        int m;
        int d;

        // Hold reset, then release it
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Year range left below year 1, then plain steps and a zero offset
        send_beat(make_beat(OP_PREV, 0, 0, 0, 0));
        send_beat(make_beat(OP_NEXT, 0, 0, 0, 0));
        send_beat(make_beat(OP_ADD, 31, 15, 65535, 0));
        // Year range left above the top year
        send_beat(make_beat(OP_LOAD, 31, 12, 65535, 0));
        send_beat(make_beat(OP_NEXT, 0, 0, 0, 0));
        send_beat(make_beat(OP_PREV, 0, 0, 0, 0));
        // Invalid loads: day 0, month 0, month above 12, year 0, bad day of month
        send_beat(make_beat(OP_LOAD, 0, 1, 2000, 0));
        send_beat(make_beat(OP_LOAD, 1, 0, 2000, 0));
        send_beat(make_beat(OP_LOAD, 1, 13, 2000, 0));
        send_beat(make_beat(OP_LOAD, 31, 15, 2000, 0));
        send_beat(make_beat(OP_LOAD, 1, 1, 0, 0));
        send_beat(make_beat(OP_LOAD, 29, 2, 1900, 0));
        send_beat(make_beat(OP_LOAD, 31, 4, 2023, 0));
        // Leap days and month ends
        send_beat(make_beat(OP_LOAD, 29, 2, 2000, 0));
        send_beat(make_beat(OP_LOAD, 28, 2, 2023, 0));
        send_beat(make_beat(OP_NEXT, 0, 0, 0, 0));
        send_beat(make_beat(OP_LOAD, 1, 3, 2024, 0));
        send_beat(make_beat(OP_PREV, 0, 0, 0, 0));
        // Offset extremes
        send_beat(make_beat(OP_LOAD, 1, 1, 2000, 0));
        send_beat(make_beat(OP_ADD, 0, 0, 0, 32767));
        send_beat(make_beat(OP_ADD, 0, 0, 0, -32768));
        send_beat(make_beat(OP_ADD, 0, 0, 0, -1));
        send_beat(make_beat(OP_LOAD, 1, 1, 1, 0));
        send_beat(make_beat(OP_ADD, 0, 0, 0, -32768));
        send_beat(make_beat(OP_LOAD, 31, 1, 65535, 0));
        send_beat(make_beat(OP_ADD, 0, 0, 0, 32767));

        // Random part: mostly a load followed by steps, the rest raw noise
        while (items_sent < 450) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat(make_beat($urandom_range(0, 3), $urandom_range(0, 31),
                    $urandom_range(0, 15), $urandom_range(0, 65535),
                    $urandom_range(0, 65535)));
            end else begin
                case ($urandom_range(0, 4))
                    0:       y = $urandom_range(1, 3);
                    1:       y = $urandom_range(65533, 65535);
                    2:       y = $urandom_range(1, 163) * 400 - $urandom_range(0, 3) * 100
                                 + $urandom_range(0, 2) - 1;
                    default: y = $urandom_range(1, 65535);
                endcase
                m = $urandom_range(1, 12);
                d = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31)
                                                : $urandom_range(1, 28);
                send_beat(make_beat(OP_LOAD, d, m, y, $urandom_range(0, 65535)));
                ops = $urandom_range(2, 8);
                repeat (ops) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2) begin
                        send_beat(make_beat(OP_NEXT, $urandom_range(0, 31),
                            $urandom_range(0, 15), $urandom_range(0, 65535), 0));
                    end else if (pick < 4) begin
                        send_beat(make_beat(OP_PREV, $urandom_range(0, 31),
                            $urandom_range(0, 15), $urandom_range(0, 65535), 0));
                    end else begin
                        pick = $urandom_range(0, 19);
                        if (pick < 8)
                            off = $urandom_range(0, 80) - 40;
                        else if (pick < 13)
                            off = $urandom_range(0, 1600) - 800;
                        else if (pick < 18)
                            off = $urandom_range(0, 65535);
                        else if (pick == 18)
                            off = 0;
                        else
                            off = $urandom_range(0, 1) ? 1 : -1;
                        send_beat(make_beat(OP_ADD, 0, 0, 0, off));
                    end
                end
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain the results, then watch a while for stray beats
        wait (pending == 0);
        repeat (64) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Give up if the run hangs
    initial begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
